@@ src/sha512_pkg.sv @@
// SHA-512 package: item structs, round constants, initial hash values, rotate helper.
// Used by sha512_core and sha512_stream_hasher.
package sha512_pkg;

    localparam int NUM_ROUNDS = 80;
    localparam int NUM_DIGEST_WORDS = 8;
    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest;
    } out_item_t;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] r;
        begin
            case (i)
                3'd0: r = 64'h6a09e667f3bcc908;
                3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b;
                3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1;
                3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] round_const(input logic [6:0] t);
        logic [63:0] k [0:79];
        begin
            k = '{
                64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
                64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
                64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
                64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
                64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
                64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
                64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
                64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
                64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
                64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
                64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
                64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
                64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
                64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
                64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
                64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
                64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
                64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
                64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
                64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
                64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
                64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
                64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
                64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
                64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
                64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
                64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
            return (t < 7'd80) ? k[t] : 64'h0;
        end
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ src/sha512_core.sv @@
// SHA-512 compression unit: one round per cycle over a 16-word rolling schedule.
// Depends on sha512_pkg. Loads words one at a time, then runs rounds on start.
module sha512_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [3:0]  load_pos,
    input  logic [63:0] load_word,
    input  logic        start,
    input  logic        clear_chain,
    output logic        busy,
    output logic [63:0] chain [0:7]
);
    import sha512_pkg::*;

    logic [63:0] sched_reg [0:15];
    logic [63:0] v_reg [0:7];
    logic [63:0] chain_reg [0:7];
    logic [6:0]  round_reg;
    logic        busy_reg;
    logic        fold_reg;

    logic [63:0] w_cur, w_new, s0w, s1w, t1, t2, big_s1, big_s0, ch, mj;
    logic [3:0]  t_lo;

    always_comb
    begin
        t_lo   = round_reg[3:0];
        s0w    = rotr64(sched_reg[t_lo + 4'd1], 1) ^ rotr64(sched_reg[t_lo + 4'd1], 8)
               ^ (sched_reg[t_lo + 4'd1] >> 7);
        s1w    = rotr64(sched_reg[t_lo + 4'd14], 19) ^ rotr64(sched_reg[t_lo + 4'd14], 61)
               ^ (sched_reg[t_lo + 4'd14] >> 6);
        w_new  = sched_reg[t_lo] + s0w + sched_reg[t_lo + 4'd9] + s1w;
        w_cur  = (round_reg < 7'd16) ? sched_reg[t_lo] : w_new;
        big_s1 = rotr64(v_reg[4], 14) ^ rotr64(v_reg[4], 18) ^ rotr64(v_reg[4], 41);
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big_s1 + ch + round_const(round_reg) + w_cur;
        big_s0 = rotr64(v_reg[0], 28) ^ rotr64(v_reg[0], 34) ^ rotr64(v_reg[0], 39);
        mj     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big_s0 + mj;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sched_reg[load_pos] <= load_word;
        end
        else if (busy_reg && round_reg >= 7'd16)
        begin
            sched_reg[t_lo] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fold_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
                v_reg[i]     <= '0;
            end
        end
        else
        begin
            fold_reg <= busy_reg && !start && (round_reg == 7'(NUM_ROUNDS - 1));
            if (clear_chain)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= init_hash(3'(i));
                end
            end
            else if (fold_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
            end
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= chain_reg[i];
                end
            end
            else if (busy_reg)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                if (round_reg == 7'(NUM_ROUNDS - 1))
                begin
                    busy_reg  <= 1'b0;
                    round_reg <= '0;
                end
                else
                begin
                    round_reg <= round_reg + 7'd1;
                end
            end
        end
    end

    // fold cycle counts as busy so the chain is settled before reuse
    assign busy = busy_reg | fold_reg;
    assign chain = chain_reg;

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) start |-> !busy;
    endproperty
    assert property (p_no_start_busy) else $error("start while compressing");

    property p_round_range;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> round_reg < 7'(NUM_ROUNDS);
    endproperty
    assert property (p_round_range) else $error("round index out of range");

    property p_fold_after_last;
        @(posedge clk) disable iff (!rst_n)
            (busy_reg && round_reg == 7'(NUM_ROUNDS - 1) && !start) |=> fold_reg;
    endproperty
    assert property (p_fold_after_last) else $error("missing fold after last round");

    property p_no_load_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !load;
    endproperty
    assert property (p_no_load_busy) else $error("schedule written during rounds");

endmodule

@@ src/sha512_stream_hasher.sv @@
// SHA-512 stream hasher top level: input sequencing, padding, digest output.
// Depends on sha512_pkg and sha512_core.
//
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_stall
//  out     | out | out_item_t | out_valid / out_stall
//
// A non-final word is loaded at once; a word that completes a 16-word block also starts
// a compression (80 rounds of the shared round unit plus the fold).
// A final word adds 1 or 2 compressions; pad words go one per cycle while core idles.
// Digest words leave one per cycle once the core is idle, while out_stall is low.
// Reset restores the initial hash values; no item is taken while busy.
module sha512_stream_hasher #(
    parameter int DIGEST_WORDS = sha512_pkg::NUM_DIGEST_WORDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha512_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha512_pkg::out_item_t out_item
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_EXTRA = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  pos_reg;
    logic [63:0] len_reg;
    logic [2:0]  oidx_reg;
    logic        pending_reg;  // second pad word (full last word) still to push
    logic        resume_reg;   // padding continues after a compression

    logic        load, start, clear_chain, core_busy;
    logic [63:0] load_word;
    logic [63:0] chain [0:7];
    logic [3:0]  vb;
    logic [63:0] mask, padded;

    sha512_core u_core (
        .clk(clk), .rst_n(rst_n), .load(load), .load_pos(pos_reg),
        .load_word(load_word), .start(start), .clear_chain(clear_chain),
        .busy(core_busy), .chain(chain)
    );

    always_comb
    begin
        vb     = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
        mask   = (vb == 4'd0) ? 64'h0 : ~(64'h0) << (7'd64 - {vb, 3'b000});
        padded = (in_item.data_word & mask) | (PAD_WORD >> {vb, 3'b000});
    end

    wire take = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || core_busy;

    always_comb
    begin
        load = 1'b0;
        load_word = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    load = 1'b1;
                    if (!in_item.last_word)
                    begin
                        load_word = in_item.data_word;
                    end
                    else if (vb == 4'd8)
                    begin
                        load_word = in_item.data_word;
                    end
                    else
                    begin
                        load_word = padded;
                    end
                end
            end
            ST_PAD:
            begin
                if (!core_busy)
                begin
                    load = 1'b1;
                    if (pending_reg)
                    begin
                        load_word = PAD_WORD;
                    end
                    else if (pos_reg == 4'd15 && !resume_reg)
                    begin
                        load_word = len_reg;
                    end
                    else
                    begin
                        load_word = '0;
                    end
                end
            end
            ST_WAIT, ST_OUT, ST_EXTRA:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign start = load && (pos_reg == 4'd15);
    assign clear_chain = out_valid && !out_stall && (oidx_reg == 3'(DIGEST_WORDS - 1));
    assign out_valid = (state_reg == ST_OUT) && !core_busy;
    assign out_item.digest_word = chain[oidx_reg];
    assign out_item.word_index  = oidx_reg;
    assign out_item.last_digest = (oidx_reg == 3'(DIGEST_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            oidx_reg    <= '0;
            pending_reg <= 1'b0;
            resume_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (!in_item.last_word)
                        begin
                            len_reg <= len_reg + 64'd64;
                        end
                        else
                        begin
                            len_reg     <= len_reg + {57'd0, vb, 3'b000};
                            pending_reg <= (vb == 4'd8);
                            // set if pad word lands at 14; at 15 it ends the block
                            resume_reg  <= (vb == 4'd8) ? (pos_reg == 4'd13)
                                                        : (pos_reg == 4'd14);
                            state_reg   <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (load)
                    begin
                        pending_reg <= 1'b0;
                        if (pos_reg == 4'd15)
                        begin
                            if (resume_reg && !pending_reg)
                            begin
                                resume_reg <= 1'b0;
                            end
                            else if (!pending_reg)
                            begin
                                state_reg <= ST_WAIT;
                            end
                        end
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_valid && !out_stall)
                    begin
                        if (oidx_reg == 3'(DIGEST_WORDS - 1))
                        begin
                            oidx_reg  <= '0;
                            len_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            oidx_reg <= oidx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    property p_out_only_in_out;
        @(posedge clk) disable iff (!rst_n) out_valid |-> state_reg == ST_OUT;
    endproperty
    assert property (p_out_only_in_out) else $error("digest shown outside output phase");

    property p_stall_when_busy;
        @(posedge clk) disable iff (!rst_n) core_busy |-> in_stall;
    endproperty
    assert property (p_stall_when_busy) else $error("input open during compression");

    property p_pos_zero_after_digest;
        @(posedge clk) disable iff (!rst_n) clear_chain |=> pos_reg == 4'd0;
    endproperty
    assert property (p_pos_zero_after_digest) else $error("position not cleared");

endmodule

@@ tb/sha512_stream_hasher_tb.sv @@
// Self-checking testbench for sha512_stream_hasher: sends messages as items, predicts
// each SHA-512 digest in its own model and compares every output item. Needs sha512_pkg.
module sha512_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha512_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    sha512_stream_hasher u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always #10 clk = ~clk;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    localparam logic [63:0] KTAB [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    // predictor state
    logic [63:0] hash_state [0:7];
    logic [63:0] block_buf [0:15];
    logic [3:0]  fill_pos;
    logic [63:0] bit_count;

    out_item_t   digest_queue [$];
    int          error_count = 0;
    int          items_sent = 0;
    int          digests_seen = 0;
    int          messages_sent = 0;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] v [0:7];
        logic [63:0] w [0:15];
        logic [63:0] wt, a, b, t1, t2;
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int j = 0; j < 16; j++) w[j] = block_buf[j];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 16) wt = w[t];
            else
            begin
                a = w[(t - 15) & 15];
                b = w[(t - 2) & 15];
                wt = w[t & 15] + (ror(a, 1) ^ ror(a, 8) ^ (a >> 7)) + w[(t - 7) & 15]
                   + (ror(b, 19) ^ ror(b, 61) ^ (b >> 6));
                w[t & 15] = wt;
            end
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + wt;
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
    endtask

    task automatic absorb_word(input logic [63:0] wd);
        block_buf[fill_pos] = wd;
        fill_pos = fill_pos + 4'd1;
        if (fill_pos == 4'd0) compress_block();
    endtask

    task automatic reset_hash();
        for (int j = 0; j < 8; j++) hash_state[j] = IV[j];
        fill_pos = '0;
        bit_count = '0;
    endtask

    task automatic predict_item(input in_item_t it);
        int vb;
        logic [63:0] mask;
        out_item_t o;
        if (!it.last_word)
        begin
            bit_count = bit_count + 64;
            absorb_word(it.data_word);
            return;
        end
        vb = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
        bit_count = bit_count + 64'(vb * 8);
        if (vb == 8)
        begin
            absorb_word(it.data_word);
            absorb_word(PAD_WORD);
        end
        else
        begin
            mask = (vb == 0) ? 64'h0 : (~64'h0 << (64 - 8 * vb));
            absorb_word((it.data_word & mask) | (PAD_WORD >> (8 * vb)));
        end
        if (fill_pos > 4'd14)
            while (fill_pos != 4'd0) absorb_word('0);
        while (fill_pos < 4'd14) absorb_word('0);
        absorb_word('0);
        absorb_word(bit_count);
        for (int j = 0; j < 8; j++)
        begin
            o.digest_word = hash_state[j];
            o.word_index = 3'(j);
            o.last_digest = (j == 7);
            digest_queue.push_back(o);
        end
        reset_hash();
    endtask

    // in_valid stays high into the next item when there is no gap
    task automatic send_item(input logic [63:0] d, input logic [3:0] vb, input logic lw);
        in_item_t it;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.data_word = d;
        it.valid_bytes = vb;
        it.last_word = lw;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        predict_item(it);
        items_sent++;
        if (lw) messages_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random message of n full words followed by a last word.
    task automatic send_message(input int n, input logic [3:0] last_vb);
        for (int k = 0; k < n; k++) send_item(rand64(), 4'($urandom_range(0, 15)), 1'b0);
        send_item(rand64(), last_vb, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge clk);
    endtask

    // output side: random stall (no new stall while messages_sent % 4 == 1), check against oldest expectation
    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("digest item with nothing expected: %h", out_item.digest_word);
                    error_count++;
                end
                else
                begin
                    exp_item = digest_queue.pop_front();
                    digests_seen++;
                    if (out_item.digest_word !== exp_item.digest_word)
                    begin
                        $error("digest_word exp %h got %h", exp_item.digest_word,
                               out_item.digest_word);
                        error_count++;
                    end
                    if (out_item.word_index !== exp_item.word_index)
                    begin
                        $error("word_index exp %0d got %0d", exp_item.word_index,
                               out_item.word_index);
                        error_count++;
                    end
                    if (out_item.last_digest !== exp_item.last_digest)
                    begin
                        $error("last_digest exp %0b got %0b", exp_item.last_digest,
                               out_item.last_digest);
                        error_count++;
                    end
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (($urandom_range(0, 2) == 0) && (messages_sent % 4 != 1))
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic test_empty_and_short();
        send_item('1, 4'd0, 1'b1);
        for (int v = 1; v <= 8; v++) send_item('1, 4'(v), 1'b1);
        send_item('0, 4'd15, 1'b1);
        send_item(64'h6162630000000000, 4'd3, 1'b1);
    endtask

    task automatic test_block_boundaries();
        send_message(13, 4'd8);
        send_message(14, 4'd0);
        send_message(15, 4'd7);
        send_message(16, 4'd4);
    endtask

    task automatic test_drain_pause();
        send_message(2, 4'd5);
        wait_drained();
        send_message(1, 4'd8);
    endtask

    task automatic test_random_messages();
        int n;
        while (items_sent < 210)
        begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 33) : $urandom_range(0, 6);
            send_message(n, 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        reset_hash();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_short();
        test_block_boundaries();
        test_drain_pause();
        test_random_messages();
        wait_drained();
        repeat (200) @(posedge clk);
        $display("Sent %0d items in %0d messages, checked %0d digest items.",
                 items_sent, messages_sent, digests_seen);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
